// File: design/ggw_pkg.sv
// Shared types and constants of the grid greedy walker.
`timescale 1ns / 1ps
package ggw_pkg;

    // Parameter defaults
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_STACK_DEPTH = 4096;

    // Fixed field widths
    localparam int COORD_W = 6;
    localparam int GRID_W  = 7;
    localparam int DIM_W   = 9;
    localparam int MOVES_W = 16;

    // Action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;

    // Cell kinds
    localparam logic [1:0] KIND_FREE    = 2'd0;
    localparam logic [1:0] KIND_VISITED = 2'd1;

    // Move directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // Configuration register indexes
    localparam logic CFG_GRID_ROWS = 1'b0;
    localparam logic CFG_GRID_COLS = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]         action;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic [1:0]         cell_kind;
        logic [COORD_W-1:0] pos_row;
        logic [COORD_W-1:0] pos_col;
        logic [COORD_W-1:0] target_row;
        logic [COORD_W-1:0] target_col;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         direction;
        logic               moved;
        logic               backtracked;
        logic               arrived;
        logic               failed;
        logic [COORD_W-1:0] cur_row;
        logic [COORD_W-1:0] cur_col;
        logic [MOVES_W-1:0] move_count;
    } t_out_item;

endpackage

// File: design/ggw_chan_if.sv
// Valid/ready stream channel carrying one payload beat.
`timescale 1ns / 1ps
interface ggw_chan_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/ggw_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ggw_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/grid_greedy_walk_backtrack_core.sv
// Greedy grid walker with backtracking: cell map RAM, path stack RAM, sequencer.
// Results: write, start, and steps that end at once (done or on target) load the
//   output register at the accept edge; a searching step runs through accept, a read
//   of each of the four neighbors through the single map read port, and decide.
// Throughput: one item at a time; a new beat is taken once the result register frees.
// Reset: synchronous, active low; then a clearing pass over all 2**(row bits + col bits)
//   map addresses (4096 at defaults) sets every map cell free, with no input accepted.
`timescale 1ns / 1ps
`default_nettype none
module grid_greedy_walk_backtrack_core
    import ggw_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ggw_chan_if.sink               i_in,
    ggw_chan_if.source             o_out,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [GRID_W-1:0] i_cfg_data
);
    // Map addressing: row and column bits concatenated
    localparam int RAW  = ($clog2(MAX_ROWS) > COORD_W) ? COORD_W : $clog2(MAX_ROWS);
    localparam int CAW  = ($clog2(MAX_COLS) > COORD_W) ? COORD_W : $clog2(MAX_COLS);
    localparam int MAW  = RAW + CAW;
    localparam int SAW  = $clog2(STACK_DEPTH);
    localparam int SCW  = $clog2(STACK_DEPTH + 1);

    typedef struct packed {
        logic                 ok;
        logic [COORD_W:0]     row;
        logic [COORD_W:0]     col;
    } t_nbr;

    // Neighbor coordinates and bounds check
    function automatic t_nbr nbr_of(input logic [1:0] d,
                                    input logic [COORD_W-1:0] r,
                                    input logic [COORD_W-1:0] c,
                                    input logic [DIM_W-1:0] rows,
                                    input logic [DIM_W-1:0] cols);
        t_nbr n;
        logic neg;
        n.row = {1'b0, r};
        n.col = {1'b0, c};
        neg   = 1'b0;
        unique case (d)
            DIR_UP: begin
                neg   = (r == '0);
                n.row = n.row - 7'd1;
            end
            DIR_DOWN:  n.row = n.row + 7'd1;
            DIR_LEFT: begin
                neg   = (c == '0);
                n.col = n.col - 7'd1;
            end
            default:   n.col = n.col + 7'd1;
        endcase
        n.ok = !neg && ({2'b00, n.row} < rows) && ({2'b00, n.col} < cols);
        return n;
    endfunction

    function automatic logic [COORD_W:0] absdiff(input logic [COORD_W:0] a,
                                                 input logic [COORD_W:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Registers
    t_state             r_state, n_state;
    logic [MAW-1:0]     r_clr_addr, n_clr_addr;
    logic [1:0]         r_idx, n_idx;
    logic               r_found, n_found;
    logic [1:0]         r_best, n_best;
    logic [COORD_W+1:0] r_bestd, n_bestd;
    logic [COORD_W-1:0] r_wrow, n_wrow, r_wcol, n_wcol;
    logic [COORD_W-1:0] r_grow, n_grow, r_gcol, n_gcol;
    logic [MOVES_W-1:0] r_moves, n_moves;
    logic               r_arrived, n_arrived, r_failed, n_failed;
    logic [SCW-1:0]     r_stk_cnt, n_stk_cnt;
    logic [GRID_W-1:0]  r_grid_rows, r_grid_cols;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    // Combinational
    logic [DIM_W-1:0]   rows_eff, cols_eff;
    logic               acc;
    t_in_item           in_d;
    t_nbr               rd_nbr, ev_nbr;
    logic [1:0]         ev_idx;
    logic               ev_en, ev_take;
    logic [COORD_W+1:0] ev_d;
    logic [SCW-1:0]     stk_dec;
    logic [1:0]         map_rdata, stk_rdata;
    logic               map_we, map_re, stk_we, stk_re;
    logic [MAW-1:0]     map_waddr, map_raddr;
    logic [1:0]         map_wdata, stk_wdata;
    logic [SAW-1:0]     stk_waddr;
    logic               out_load;
    logic [1:0]         res_dir;
    logic               res_moved, res_back;
    logic               fin_found;
    logic [1:0]         fin_best;
    logic               walker_in_store;

    // Effective grid size: zero counts as one, clamp to the maximum
    always_comb begin
        if (r_grid_rows == '0) begin
            rows_eff = DIM_W'(1);
        end else if ({2'b00, r_grid_rows} > DIM_W'(MAX_ROWS)) begin
            rows_eff = DIM_W'(MAX_ROWS);
        end else begin
            rows_eff = {2'b00, r_grid_rows};
        end
        if (r_grid_cols == '0) begin
            cols_eff = DIM_W'(1);
        end else if ({2'b00, r_grid_cols} > DIM_W'(MAX_COLS)) begin
            cols_eff = DIM_W'(MAX_COLS);
        end else begin
            cols_eff = {2'b00, r_grid_cols};
        end
    end

    assign in_d        = i_in.data;
    assign i_in.ready  = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign acc         = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign walker_in_store = ({3'b000, r_wrow} < DIM_W'(MAX_ROWS)) &&
                             ({3'b000, r_wcol} < DIM_W'(MAX_COLS));

    // Neighbor being read and neighbor whose cell data arrived
    assign rd_nbr  = nbr_of(r_idx, r_wrow, r_wcol, rows_eff, cols_eff);
    assign ev_idx  = (r_state == S_FIN) ? DIR_RIGHT : r_idx - 2'd1;
    assign ev_en   = (r_state == S_FIN) || ((r_state == S_SCAN) && (r_idx != 2'd0));
    assign ev_nbr  = nbr_of(ev_idx, r_wrow, r_wcol, rows_eff, cols_eff);
    assign ev_d    = {1'b0, absdiff({1'b0, r_grow}, ev_nbr.row)} +
                     {1'b0, absdiff({1'b0, r_gcol}, ev_nbr.col)};
    assign ev_take = ev_en && ev_nbr.ok && (map_rdata == KIND_FREE) &&
                     (!r_found || (ev_d < r_bestd));

    assign fin_found = r_found || ev_take;
    assign fin_best  = ev_take ? ev_idx : r_best;
    assign stk_dec   = r_stk_cnt - SCW'(1);

    // Map read: one neighbor per scan cycle
    assign map_re    = (r_state == S_SCAN);
    assign map_raddr = {rd_nbr.row[RAW-1:0], rd_nbr.col[CAW-1:0]};

    // Stack read of the top entry at scan start, held for a pop at decide
    assign stk_re    = (r_state == S_SCAN) && (r_idx == 2'd0);

    // Sequencer: next state, result and RAM writes
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_idx       = r_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_bestd     = r_bestd;
        n_wrow      = r_wrow;
        n_wcol      = r_wcol;
        n_grow      = r_grow;
        n_gcol      = r_gcol;
        n_moves     = r_moves;
        n_arrived   = r_arrived;
        n_failed    = r_failed;
        n_stk_cnt   = r_stk_cnt;
        out_load    = 1'b0;
        res_dir     = DIR_UP;
        res_moved   = 1'b0;
        res_back    = 1'b0;
        map_we      = 1'b0;
        map_waddr   = {in_d.cell_row[RAW-1:0], in_d.cell_col[CAW-1:0]};
        map_wdata   = in_d.cell_kind;
        stk_we      = 1'b0;
        stk_waddr   = r_stk_cnt[SAW-1:0];
        stk_wdata   = fin_best;

        if (ev_take) begin
            n_found = 1'b1;
            n_best  = ev_idx;
            n_bestd = ev_d;
        end

        unique case (r_state)
            S_CLEAR: begin
                map_we     = 1'b1;
                map_waddr  = r_clr_addr;
                map_wdata  = KIND_FREE;
                n_clr_addr = r_clr_addr + MAW'(1);
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    unique case (in_d.action)
                        ACT_WRITE: begin
                            map_we   = ({3'b000, in_d.cell_row} < DIM_W'(MAX_ROWS)) &&
                                       ({3'b000, in_d.cell_col} < DIM_W'(MAX_COLS));
                            out_load = 1'b1;
                        end
                        ACT_START: begin
                            n_wrow    = in_d.pos_row;
                            n_wcol    = in_d.pos_col;
                            n_grow    = in_d.target_row;
                            n_gcol    = in_d.target_col;
                            n_stk_cnt = '0;
                            n_moves   = '0;
                            n_arrived = (in_d.pos_row == in_d.target_row) &&
                                        (in_d.pos_col == in_d.target_col);
                            n_failed  = 1'b0;
                            out_load  = 1'b1;
                        end
                        ACT_STEP: begin
                            priority if (r_arrived || r_failed) begin
                                out_load = 1'b1;
                            end else if ((r_wrow == r_grow) && (r_wcol == r_gcol)) begin
                                n_arrived = 1'b1;
                                out_load  = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                                n_idx   = 2'd0;
                                n_found = 1'b0;
                            end
                        end
                        default: out_load = 1'b1;
                    endcase
                end
            end
            S_SCAN: begin
                n_idx = r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    n_state = S_FIN;
                end
            end
            default: begin
                // Decide: mark visited, then forward, fail or backtrack
                map_we    = walker_in_store;
                map_waddr = {r_wrow[RAW-1:0], r_wcol[CAW-1:0]};
                map_wdata = KIND_VISITED;
                priority if (fin_found) begin
                    if (r_stk_cnt < SCW'(STACK_DEPTH)) begin
                        stk_we    = 1'b1;
                        n_stk_cnt = r_stk_cnt + SCW'(1);
                    end
                    res_dir   = fin_best;
                    res_moved = 1'b1;
                end else if (r_stk_cnt == '0) begin
                    n_failed = 1'b1;
                end else begin
                    n_stk_cnt = stk_dec;
                    res_dir   = stk_rdata ^ 2'b01;
                    res_moved = 1'b1;
                    res_back  = 1'b1;
                end
                if (res_moved) begin
                    unique case (res_dir)
                        DIR_UP:   n_wrow = r_wrow - COORD_W'(1);
                        DIR_DOWN: n_wrow = r_wrow + COORD_W'(1);
                        DIR_LEFT: n_wcol = r_wcol - COORD_W'(1);
                        default:  n_wcol = r_wcol + COORD_W'(1);
                    endcase
                    if (r_moves != '1) begin
                        n_moves = r_moves + MOVES_W'(1);
                    end
                    if ((n_wrow == r_grow) && (n_wcol == r_gcol)) begin
                        n_arrived = 1'b1;
                    end
                end
                out_load = 1'b1;
                n_state  = S_IDLE;
            end
        endcase

        // Result register
        n_out_valid = (r_out_valid && !o_out.ready) || out_load;
        n_out       = r_out;
        if (out_load) begin
            n_out.direction   = res_dir;
            n_out.moved       = res_moved;
            n_out.backtracked = res_back;
            n_out.arrived     = n_arrived;
            n_out.failed      = n_failed;
            n_out.cur_row     = n_wrow;
            n_out.cur_col     = n_wcol;
            n_out.move_count  = n_moves;
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_wrow      <= '0;
            r_wcol      <= '0;
            r_grow      <= '0;
            r_gcol      <= '0;
            r_moves     <= '0;
            r_arrived   <= 1'b0;
            r_failed    <= 1'b0;
            r_stk_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_wrow      <= n_wrow;
            r_wcol      <= n_wcol;
            r_grow      <= n_grow;
            r_gcol      <= n_gcol;
            r_moves     <= n_moves;
            r_arrived   <= n_arrived;
            r_failed    <= n_failed;
            r_stk_cnt   <= n_stk_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_best  <= n_best;
        r_bestd <= n_bestd;
        r_out   <= n_out;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= GRID_W'(64);
            r_grid_cols <= GRID_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                default:       r_grid_cols <= i_cfg_data;
            endcase
        end
    end

    // Cell map
    ggw_ram #(
        .WIDTH (2),
        .DEPTH (2 ** MAW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    // Path stack
    ggw_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_dec[SAW-1:0]),
        .o_rdata (stk_rdata)
    );

    // Assertions
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("input accepted during map clearing pass");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_arrived && r_failed))
        else $error("arrived and failed both set");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stk_cnt <= SCW'(STACK_DEPTH))
        else $error("path stack count beyond depth");

    a_back_implies_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.backtracked) |-> r_out.moved)
        else $error("backtrack reported without a move");

    a_decide_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("step decision did not produce a result");
endmodule
`default_nettype wire

// File: bench/grid_greedy_walk_backtrack_core_tb.sv
// Self-checking testbench for the grid greedy walker: directed and random traffic.
`timescale 1ns / 1ps
module grid_greedy_walk_backtrack_core_tb;
    import ggw_pkg::*;

    // Cell kinds and the idle action that the package leaves unnamed
    localparam logic [1:0] KIND_WALL = 2'd2;
    localparam logic [1:0] KIND_MARK = 2'd3;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam int MAP_CELLS    = DEF_MAX_ROWS * DEF_MAX_COLS;
    localparam int MOVES_MAX    = 65535;
    localparam int QUIET_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [GRID_W-1:0] i_cfg_data;

    ggw_chan_if #(.T(t_in_item))  in_if ();
    ggw_chan_if #(.T(t_out_item)) out_if ();

    grid_greedy_walk_backtrack_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stimulus and expected reports
    t_in_item  walk_items [$];
    t_out_item awaited_reports [$];
    int        items_queued    = 0;
    int        results_checked = 0;
    int        fail_count      = 0;
    int        send_idle_pct   = 0;
    int        recv_stall_pct  = 0;
    bit        hold_wanted     = 1'b0;
    bit        hold_taken;
    int        hold_left;
    int        quiet_cycles    = 0;
    t_out_item report_want;

    // Walker shadow state
    logic [1:0]         cell_map [MAP_CELLS];
    logic [1:0]         path_stack [DEF_STACK_DEPTH];
    int                 stack_used;
    logic [COORD_W-1:0] walker_row, walker_col, goal_row, goal_col;
    int                 moves_made;
    bit                 arrived_flag, failed_flag;
    logic [GRID_W-1:0]  grid_rows_reg, grid_cols_reg;

    // Register value to rows or columns in use
    function automatic int grid_span(logic [GRID_W-1:0] v);
        if (v == 0) return 1;
        if (v > DEF_MAX_ROWS) return DEF_MAX_ROWS;
        return int'(v);
    endfunction

    // Neighbor may be entered: in use on both axes and free
    function automatic bit cell_open(int r, int c);
        if (r < 0 || c < 0) return 1'b0;
        if (r >= grid_span(grid_rows_reg) || c >= grid_span(grid_cols_reg)) return 1'b0;
        if (r >= DEF_MAX_ROWS || c >= DEF_MAX_COLS) return 1'b0;
        return cell_map[r * DEF_MAX_COLS + c] == KIND_FREE;
    endfunction

    // Advance the shadow walker by one item and return its report
    function automatic t_out_item predict_walk(t_in_item it);
        t_out_item  res;
        logic [1:0] dir, best, dir_k;
        bit         found, moved, back;
        int         k, nr, nc, dr_abs, dc_abs, dist_k, best_dist;
        res   = '0;
        dir   = DIR_UP;
        moved = 1'b0;
        back  = 1'b0;
        case (it.action)
            ACT_WRITE: begin
                cell_map[it.cell_row * DEF_MAX_COLS + it.cell_col] = it.cell_kind;
            end
            ACT_START: begin
                walker_row   = it.pos_row;
                walker_col   = it.pos_col;
                goal_row     = it.target_row;
                goal_col     = it.target_col;
                stack_used   = 0;
                moves_made   = 0;
                arrived_flag = (it.pos_row == it.target_row) && (it.pos_col == it.target_col);
                failed_flag  = 1'b0;
            end
            ACT_STEP: begin
                if (!arrived_flag && !failed_flag) begin
                    if (walker_row == goal_row && walker_col == goal_col) begin
                        arrived_flag = 1'b1;
                    end else begin
                        found     = 1'b0;
                        best      = DIR_UP;
                        best_dist = 0;
                        // scan in tie order: up, down, left, right
                        for (k = 0; k < 4; k++) begin
                            dir_k = k[1:0];
                            nr    = int'(walker_row);
                            nc    = int'(walker_col);
                            case (dir_k)
                                DIR_UP:   nr = nr - 1;
                                DIR_DOWN: nr = nr + 1;
                                DIR_LEFT: nc = nc - 1;
                                default:  nc = nc + 1;
                            endcase
                            if (cell_open(nr, nc)) begin
                                dr_abs = int'(goal_row) - nr;
                                dc_abs = int'(goal_col) - nc;
                                if (dr_abs < 0) dr_abs = -dr_abs;
                                if (dc_abs < 0) dc_abs = -dc_abs;
                                dist_k = dr_abs + dc_abs;
                                if (!found || dist_k < best_dist) begin
                                    found     = 1'b1;
                                    best_dist = dist_k;
                                    best      = dir_k;
                                end
                            end
                        end
                        cell_map[walker_row * DEF_MAX_COLS + walker_col] = KIND_VISITED;
                        if (found) begin
                            // full stack: move anyway, push dropped
                            if (stack_used < DEF_STACK_DEPTH) begin
                                path_stack[stack_used] = best;
                                stack_used++;
                            end
                            dir   = best;
                            moved = 1'b1;
                        end else if (stack_used == 0) begin
                            failed_flag = 1'b1;
                        end else begin
                            stack_used--;
                            dir   = path_stack[stack_used] ^ 2'b01;
                            moved = 1'b1;
                            back  = 1'b1;
                        end
                        if (moved) begin
                            // coordinates wrap within 6 bits
                            case (dir)
                                DIR_UP:   walker_row = walker_row - 1'b1;
                                DIR_DOWN: walker_row = walker_row + 1'b1;
                                DIR_LEFT: walker_col = walker_col - 1'b1;
                                default:  walker_col = walker_col + 1'b1;
                            endcase
                            if (moves_made < MOVES_MAX) moves_made++;
                            if (walker_row == goal_row && walker_col == goal_col) begin
                                arrived_flag = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        res.direction   = dir;
        res.moved       = moved;
        res.backtracked = back;
        res.arrived     = arrived_flag;
        res.failed      = failed_flag;
        res.cur_row     = walker_row;
        res.cur_col     = walker_col;
        res.move_count  = moves_made[MOVES_W-1:0];
        return res;
    endfunction

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // Input driver: one beat per handshake, random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                awaited_reports.push_back(predict_walk(in_if.data));
            end
            if (!in_if.valid || in_if.ready) begin
                if (walk_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_if.data  <= walk_items.pop_front();
                    in_if.valid <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check each beat, random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_taken   <= 1'b0;
            hold_left    <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (awaited_reports.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got %p",
                             $time, out_if.data);
                    fail_count++;
                end else begin
                    report_want = awaited_reports.pop_front();
                    check_field("direction", 16'(report_want.direction),
                                16'(out_if.data.direction));
                    check_field("moved", 16'(report_want.moved), 16'(out_if.data.moved));
                    check_field("backtracked", 16'(report_want.backtracked),
                                16'(out_if.data.backtracked));
                    check_field("arrived", 16'(report_want.arrived),
                                16'(out_if.data.arrived));
                    check_field("failed", 16'(report_want.failed), 16'(out_if.data.failed));
                    check_field("cur_row", 16'(report_want.cur_row),
                                16'(out_if.data.cur_row));
                    check_field("cur_col", 16'(report_want.cur_col),
                                16'(out_if.data.cur_col));
                    check_field("move_count", report_want.move_count, out_if.data.move_count);
                end
                results_checked <= results_checked + 1;
            end
            if (hold_wanted && !hold_taken) begin
                hold_taken   <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic queue_item(logic [1:0] act, logic [COORD_W-1:0] cr, logic [COORD_W-1:0] cc,
                              logic [1:0] kind, logic [COORD_W-1:0] pr,
                              logic [COORD_W-1:0] pc, logic [COORD_W-1:0] tr,
                              logic [COORD_W-1:0] tc);
        t_in_item it;
        it.action     = act;
        it.cell_row   = cr;
        it.cell_col   = cc;
        it.cell_kind  = kind;
        it.pos_row    = pr;
        it.pos_col    = pc;
        it.target_row = tr;
        it.target_col = tc;
        walk_items.push_back(it);
        items_queued++;
    endtask

    task automatic q_write(int r, int c, logic [1:0] kind);
        queue_item(ACT_WRITE, r[COORD_W-1:0], c[COORD_W-1:0], kind,
                   COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom));
    endtask

    task automatic q_start(int pr, int pc, int tr, int tc);
        queue_item(ACT_START, COORD_W'($urandom), COORD_W'($urandom), 2'($urandom),
                   pr[COORD_W-1:0], pc[COORD_W-1:0], tr[COORD_W-1:0], tc[COORD_W-1:0]);
    endtask

    task automatic q_step();
        queue_item(ACT_STEP, COORD_W'($urandom), COORD_W'($urandom), 2'($urandom),
                   COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom));
    endtask

    // Wait until every queued item has returned its report
    task automatic wait_drain();
        while (results_checked != items_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Grid size write, block idle
    task automatic set_grid(logic [GRID_W-1:0] rows, logic [GRID_W-1:0] cols);
        @(posedge i_clk);
        i_cfg_we      <= 1'b1;
        i_cfg_idx     <= CFG_GRID_ROWS;
        i_cfg_data    <= rows;
        grid_rows_reg  = rows;
        @(posedge i_clk);
        i_cfg_idx     <= CFG_GRID_COLS;
        i_cfg_data    <= cols;
        grid_cols_reg  = cols;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
    endtask

    // One search: map a window, start, then a run of steps; some noise first
    task automatic add_episode(int rows, int cols);
        int         wr, wc, r0, c0, n, k, r, c, roll;
        int         pr, pc, tr, tc;
        logic [1:0] kind;
        wr = (rows < 8) ? rows : 8;
        wc = (cols < 8) ? cols : 8;
        r0 = $urandom_range(rows - wr);
        c0 = $urandom_range(cols - wc);
        if ($urandom_range(99) < 25) begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) begin
                queue_item(2'($urandom_range(3)), COORD_W'($urandom), COORD_W'($urandom),
                           2'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                           COORD_W'($urandom), COORD_W'($urandom));
            end
        end
        if ($urandom_range(1) == 0) begin
            // rewrite the whole window, mostly free
            for (r = 0; r < wr; r++) begin
                for (c = 0; c < wc; c++) begin
                    roll = $urandom_range(99);
                    if (roll < 70) kind = KIND_FREE;
                    else if (roll < 88) kind = KIND_WALL;
                    else if (roll < 94) kind = KIND_VISITED;
                    else kind = KIND_MARK;
                    q_write(r0 + r, c0 + c, kind);
                end
            end
        end else begin
            n = $urandom_range(0, 4);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(99) < 20) begin
                    q_write($urandom_range(63), $urandom_range(63), 2'($urandom_range(3)));
                end else begin
                    q_write(r0 + $urandom_range(wr - 1), c0 + $urandom_range(wc - 1),
                            2'($urandom_range(3)));
                end
            end
        end
        if ($urandom_range(99) < 90) begin
            pr = r0 + $urandom_range(wr - 1);
            pc = c0 + $urandom_range(wc - 1);
        end else begin
            pr = $urandom_range(63);
            pc = $urandom_range(63);
        end
        roll = $urandom_range(99);
        if (roll < 70) begin
            tr = r0 + $urandom_range(wr - 1);
            tc = c0 + $urandom_range(wc - 1);
        end else if (roll < 90) begin
            tr = $urandom_range(rows - 1);
            tc = $urandom_range(cols - 1);
        end else begin
            tr = $urandom_range(63);
            tc = $urandom_range(63);
        end
        q_start(pr, pc, tr, tc);
        n = 2 * wr * wc + 4;
        if (n > 70) n = 70;
        n = $urandom_range(1, n);
        for (k = 0; k < n; k++) q_step();
    endtask

    task automatic run_phase(logic [GRID_W-1:0] rows, logic [GRID_W-1:0] cols,
                             int send_pct, int recv_pct, int n_items);
        int first;
        set_grid(rows, cols);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        first = items_queued;
        while (items_queued - first < n_items) add_episode(grid_span(rows), grid_span(cols));
        wait_drain();
    endtask

    initial begin
        int k;
        // known values before the first edge
        in_if.valid   = 1'b0;
        in_if.data    = '0;
        out_if.ready  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_GRID_ROWS;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        for (k = 0; k < MAP_CELLS; k++) cell_map[k] = KIND_FREE;
        for (k = 0; k < DEF_STACK_DEPTH; k++) path_stack[k] = DIR_UP;
        stack_used    = 0;
        walker_row    = '0;
        walker_col    = '0;
        goal_row      = '0;
        goal_col      = '0;
        moves_made    = 0;
        arrived_flag  = 1'b0;
        failed_flag   = 1'b0;
        grid_rows_reg = GRID_W'(DEF_MAX_ROWS);
        grid_cols_reg = GRID_W'(DEF_MAX_COLS);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset state, idle action, boxed-in failure, plain moves, tie order
        q_step();                       // walker already on target after reset
        q_step();                       // no change once arrived
        queue_item(ACT_NONE, '1, '1, KIND_MARK, '1, '1, '1, '1);
        q_write(1, 0, KIND_VISITED);
        q_write(0, 1, KIND_MARK);
        q_start(0, 0, 63, 63);
        q_step();                       // boxed in, empty stack
        q_step();                       // no change once failed
        q_write(0, 1, KIND_FREE);
        q_start(0, 0, 0, 2);
        q_step();
        q_step();
        q_step();
        q_write(63, 63, KIND_WALL);
        q_start(63, 63, 0, 0);
        q_step();                       // up and left tie
        q_step();
        q_start(33, 33, 33, 33);        // start on target
        q_step();
        q_write(63, 63, KIND_FREE);
        wait_drain();

        // Random phases over sizes and idling patterns
        run_phase(7'd8, 7'd8, 0, 0, 80);
        run_phase(7'd6, 7'd9, 76, 0, 80);
        hold_wanted = 1'b1;
        run_phase(7'd5, 7'd5, 0, 76, 80);
        run_phase(7'd12, 7'd4, 13, 13, 80);
        run_phase(7'd0, 7'd3, 0, 0, 40);
        run_phase(7'd127, 7'd100, 76, 0, 80);
        run_phase(7'd1, 7'd64, 0, 76, 60);
        run_phase(7'd64, 7'd1, 13, 13, 60);
        run_phase(7'd3, 7'd127, 0, 0, 60);
        run_phase(7'd16, 7'd16, 13, 13, 80);

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && awaited_reports.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
design/ggw_pkg.sv
design/ggw_chan_if.sv
design/ggw_ram.sv
design/grid_greedy_walk_backtrack_core.sv
bench/grid_greedy_walk_backtrack_core_tb.sv
